### sv/pgh_pkg.sv
// Shared types, constants and the character table of the planar geohash encoder.
package pgh_pkg;

    localparam int MAXC_W              = 31;
    localparam int BPA_W               = 5;
    localparam int GROUP_W             = 5;
    localparam int CHAR_W              = 8;
    localparam int DATA_W              = 32;
    localparam int ADDR_W              = 3;
    localparam int DEF_MAX_BITS        = 16;
    localparam int DEF_COORD_WIDTH     = 32;
    localparam logic [MAXC_W-1:0] MAXC_RESET = 31'h7fff_ffff;
    localparam logic [BPA_W-1:0]  BPA_RESET  = 5'd10;
    localparam logic [CHAR_W-1:0] ERR_CHAR   = 8'h00;

    localparam logic [32*CHAR_W-1:0] GH_ALPHA = "0123456789bcdefghjkmnpqrstuvwxyz";

    typedef enum logic {
        REG_MAX_COORD     = 1'b0,
        REG_BITS_PER_AXIS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic vld;
        logic err;
    } t_tag;

    function automatic logic [CHAR_W-1:0] gh_char(input logic [GROUP_W-1:0] idx);
        logic [GROUP_W-1:0] pos;
        pos = 5'd31 - idx;
        return GH_ALPHA[CHAR_W*pos +: CHAR_W];
    endfunction

endpackage

### sv/pgh_div_lane.sv
// One lane of the pipelined restoring divider that turns a coordinate into its segment index.
module pgh_div_lane
    import pgh_pkg::*;
#(
    parameter int MAX_BITS = DEF_MAX_BITS
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [MAXC_W-1:0] i_coord,
    input  logic [MAXC_W-1:0] i_div,
    output logic [MAX_BITS-1:0] o_quot
);

    logic [MAXC_W-1:0]   r_rem [MAX_BITS];
    logic [MAX_BITS-1:0] r_q   [MAX_BITS];
    logic [MAXC_W-1:0]   n_rem [MAX_BITS];
    logic [MAX_BITS-1:0] n_q   [MAX_BITS];

    always_comb begin
        logic [MAXC_W:0] t;
        logic            ge;
        for (int s = 0; s < MAX_BITS; s++) begin
            if (s == 0) begin
                t = {i_coord, 1'b0};
            end else begin
                t = {r_rem[s-1], 1'b0};
            end
            ge = (t >= {1'b0, i_div});
            n_rem[s] = ge ? MAXC_W'(t - {1'b0, i_div}) : t[MAXC_W-1:0];
            if (s == 0) begin
                n_q[s] = {{(MAX_BITS-1){1'b0}}, ge};
            end else begin
                n_q[s] = {r_q[s-1][MAX_BITS-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < MAX_BITS; s++) begin
                r_rem[s] <= n_rem[s];
                r_q[s]   <= n_q[s];
            end
        end
    end

    assign o_quot = r_q[MAX_BITS-1];

endmodule

### sv/pgh_emit.sv
// Merging stage: interleaves the lane results and sends the Base32 characters one per cycle.
module pgh_emit
    import pgh_pkg::*;
#(
    parameter int MAX_BITS = DEF_MAX_BITS,
    parameter int NW       = $clog2(MAX_BITS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_err,
    input  logic [MAX_BITS-1:0] i_qx,
    input  logic [MAX_BITS-1:0] i_qy,
    input  logic [NW-1:0]       i_nbits,
    output logic                o_free,
    output logic                o_valid,
    output logic [CHAR_W-1:0]   o_char,
    output logic                o_last,
    output logic                o_err
);

    localparam int NCH  = (2 * MAX_BITS + GROUP_W - 1) / GROUP_W;
    localparam int WW   = NCH * GROUP_W;
    localparam int CNTW = $clog2(NCH + 1);

    logic            r_act;
    logic [WW-1:0]   r_sh;
    logic [CNTW-1:0] r_cnt;
    logic            r_err;
    logic            r_valid;
    logic [CHAR_W-1:0] r_char;
    logic            r_last;
    logic            r_oerr;

    logic [WW-1:0]   n_word;
    logic [CNTW-1:0] n_chars;
    logic [NW:0]     nb2;
    logic            at_last;

    assign nb2     = {i_nbits, 1'b0};
    assign at_last = (r_cnt == CNTW'(1));
    assign o_free  = !r_act || at_last;

    always_comb begin
        logic [WW-1:0] ileave;
        ileave = '0;
        for (int i = 0; i < MAX_BITS; i++) begin
            ileave[WW-1-2*i] = i_qx[MAX_BITS-1-i];
            ileave[WW-2-2*i] = i_qy[MAX_BITS-1-i];
        end
        n_word  = ileave & ~({WW{1'b1}} >> nb2);
        n_chars = '0;
        for (int k = 0; k < NCH; k++) begin
            if (32'(k * GROUP_W) < 32'(nb2)) begin
                n_chars = n_chars + CNTW'(1);
            end
        end
        if (i_err) begin
            n_chars = CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_act;
            if (i_load) begin
                r_act <= 1'b1;
            end else if (at_last) begin
                r_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_act) begin
            r_char <= r_err ? ERR_CHAR : gh_char(r_sh[WW-1 -: GROUP_W]);
            r_last <= at_last;
            r_oerr <= r_err;
        end
        if (i_load) begin
            r_sh  <= n_word;
            r_cnt <= n_chars;
            r_err <= i_err;
        end else if (r_act) begin
            r_sh  <= r_sh << GROUP_W;
            r_cnt <= r_cnt - CNTW'(1);
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;
    assign o_err   = r_oerr;

endmodule

### sv/planar_geohash_encoder.sv
// Top level of the planar geohash encoder: register port, range check, divider lanes, emitter.
//
//  channel   direction  handshake                  payload
//  point     in         start, busy                i_x_coord, i_y_coord
//  hash      out        o_hash_valid (strobe)      o_hash_char, o_last, o_range_error
//  config    in/out     psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// The first character of a taken point leaves via the coordinate registers, the divider lane stages,
// the emitter shift register and its character register. Each point holds the emitter, which sets
// the pace of points, until its last character is sent (one for an error); the divider lanes take
// a new point every cycle while busy is low. Reset clears the control flags and loads the register defaults.
// The receiver cannot stall; busy is high only while a finished point waits for the emitter.
module planar_geohash_encoder
    import pgh_pkg::*;
#(
    parameter int MAX_BITS_PER_AXIS = DEF_MAX_BITS,
    parameter int COORD_WIDTH       = DEF_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [COORD_WIDTH-1:0] i_y_coord,
    output logic                          o_hash_valid,
    output logic [CHAR_W-1:0]             o_hash_char,
    output logic                          o_last,
    output logic                          o_range_error,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready
);

    localparam int NW   = $clog2(MAX_BITS_PER_AXIS + 1);
    localparam int CMPW = (COORD_WIDTH - 1 > MAXC_W) ? COORD_WIDTH - 1 : MAXC_W;

    logic [MAXC_W-1:0] r_max;
    logic [BPA_W-1:0]  r_bits;
    t_reg_idx          reg_idx;

    t_tag              r_tag [MAX_BITS_PER_AXIS+1];
    t_tag              n_tag0;
    logic [MAXC_W-1:0] r_cx;
    logic [MAXC_W-1:0] r_cy;

    logic [CMPW-1:0]   mag_x;
    logic [CMPW-1:0]   mag_y;
    logic              adv;
    logic              em_free;
    logic              em_load;
    logic [NW-1:0]     n_eff;
    logic [MAX_BITS_PER_AXIS-1:0] qx;
    logic [MAX_BITS_PER_AXIS-1:0] qy;

    assign reg_idx = t_reg_idx'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= MAXC_RESET;
            r_bits <= BPA_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_MAX_COORD:     r_max  <= pwdata[MAXC_W-1:0];
                REG_BITS_PER_AXIS: r_bits <= pwdata[BPA_W-1:0];
                default:           r_max  <= r_max;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAX_COORD:     prdata = DATA_W'(r_max);
            REG_BITS_PER_AXIS: prdata = DATA_W'(r_bits);
            default:           prdata = '0;
        endcase
    end

    assign mag_x = CMPW'(i_x_coord[COORD_WIDTH-2:0]);
    assign mag_y = CMPW'(i_y_coord[COORD_WIDTH-2:0]);

    always_comb begin
        n_tag0.vld = start && !busy;
        n_tag0.err = i_x_coord[COORD_WIDTH-1] || i_y_coord[COORD_WIDTH-1]
                  || (mag_x >= CMPW'(r_max)) || (mag_y >= CMPW'(r_max));
    end

    assign adv     = !r_tag[MAX_BITS_PER_AXIS].vld || em_free;
    assign busy    = !adv;
    assign em_load = r_tag[MAX_BITS_PER_AXIS].vld && em_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= MAX_BITS_PER_AXIS; s++) begin
                r_tag[s] <= '0;
            end
        end else if (adv) begin
            r_tag[0] <= n_tag0;
            for (int s = 1; s <= MAX_BITS_PER_AXIS; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cx <= mag_x[MAXC_W-1:0];
            r_cy <= mag_y[MAXC_W-1:0];
        end
    end

    always_comb begin
        if (r_bits <= BPA_W'(1)) begin
            n_eff = NW'(2);
        end else if (r_bits > BPA_W'(MAX_BITS_PER_AXIS)) begin
            n_eff = NW'(MAX_BITS_PER_AXIS);
        end else begin
            n_eff = NW'(r_bits);
        end
    end

    pgh_div_lane #(
        .MAX_BITS(MAX_BITS_PER_AXIS)
    ) u_lane_x (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_coord(r_cx),
        .i_div  (r_max),
        .o_quot (qx)
    );

    pgh_div_lane #(
        .MAX_BITS(MAX_BITS_PER_AXIS)
    ) u_lane_y (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_coord(r_cy),
        .i_div  (r_max),
        .o_quot (qy)
    );

    pgh_emit #(
        .MAX_BITS(MAX_BITS_PER_AXIS),
        .NW      (NW)
    ) u_emit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (em_load),
        .i_err  (r_tag[MAX_BITS_PER_AXIS].err),
        .i_qx   (qx),
        .i_qy   (qy),
        .i_nbits(n_eff),
        .o_free (em_free),
        .o_valid(o_hash_valid),
        .o_char (o_hash_char),
        .o_last (o_last),
        .o_err  (o_range_error)
    );

`ifndef SYNTHESIS
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hash_valid && o_range_error |-> o_last && (o_hash_char == ERR_CHAR))
        else $error("Error beat is not a single zero character.");

    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hash_valid && !o_last |=> o_hash_valid)
        else $error("Character run broke before its last beat.");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> r_tag[MAX_BITS_PER_AXIS].vld && !em_free)
        else $error("Busy without a finished point waiting.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> $stable(r_tag[MAX_BITS_PER_AXIS]))
        else $error("Waiting point changed during a stall.");
`endif

endmodule

### sim/tb_planar_geohash_encoder.sv
// Self-checking testbench of the planar geohash encoder: point driver, character monitor, APB setup.
`timescale 1ns / 1ps

module tb_planar_geohash_encoder;
    import pgh_pkg::*;

    localparam int AXIS_BITS_MAX  = DEF_MAX_BITS;
    localparam int SETTLE_CYCLES  = AXIS_BITS_MAX + 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 100;
    localparam logic [255:0] GEO_ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";
    localparam logic [31:0] FULL_EXTENT = 32'h7fff_ffff;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
    } t_point;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
        logic              is_err;
    } t_hash_beat;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic signed [DATA_W-1:0]      x_coord = '0;
    logic signed [DATA_W-1:0]      y_coord = '0;
    logic                          o_hash_valid;
    logic [CHAR_W-1:0]             o_hash_char;
    logic                          o_last;
    logic                          o_range_error;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [ADDR_W-1:0]             paddr = '0;
    logic [DATA_W-1:0]             pwdata = '0;
    logic [DATA_W-1:0]             prdata;
    logic                          pready;

    t_point         pending_points[$];
    t_hash_beat     expected_chars[$];
    t_point         next_point;
    logic [MAXC_W-1:0] extent_cfg = MAXC_RESET;
    logic [BPA_W-1:0]  axis_bits_cfg = BPA_RESET;
    int n_queued = 0;
    int n_points = 0;
    int n_chars = 0;
    int n_err_beats = 0;
    int n_fail = 0;
    int n_phases = 0;
    int gap_pct = 0;
    int idle_left = 0;
    int stall_cycles = 0;

    planar_geohash_encoder #(
        .MAX_BITS_PER_AXIS(AXIS_BITS_MAX),
        .COORD_WIDTH      (DATA_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_x_coord    (x_coord),
        .i_y_coord    (y_coord),
        .o_hash_valid (o_hash_valid),
        .o_hash_char  (o_hash_char),
        .o_last       (o_last),
        .o_range_error(o_range_error),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_fail < PRINT_LIMIT) begin
            $display("MISMATCH at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        end
        n_fail++;
    endtask

    // Works out the characters of one point under the current geometry.
    function automatic void encode_point(input logic [31:0] xv, input logic [31:0] yv);
        t_hash_beat  beat;
        logic [63:0] xi, yi, code, top;
        int          n, nch, pad, grp;
        if (xv[31] || yv[31] || xv >= {1'b0, extent_cfg} || yv >= {1'b0, extent_cfg}) begin
            beat.ch = ERR_CHAR;
            beat.is_last = 1'b1;
            beat.is_err = 1'b1;
            expected_chars = {expected_chars, beat};
        end else begin
            n = int'(axis_bits_cfg);
            if (n <= 1) begin
                n = 2;
            end
            if (n > AXIS_BITS_MAX) begin
                n = AXIS_BITS_MAX;
            end
            top = 64'd1 << n;
            xi = ({32'd0, xv} << n) / {33'd0, extent_cfg};
            yi = ({32'd0, yv} << n) / {33'd0, extent_cfg};
            if (xi >= top) begin
                xi = top - 1;
            end
            if (yi >= top) begin
                yi = top - 1;
            end
            code = '0;
            for (int i = n - 1; i >= 0; i--) begin
                code = (code << 1) | 64'(xi[i]);
                code = (code << 1) | 64'(yi[i]);
            end
            nch = (2 * n + GROUP_W - 1) / GROUP_W;
            pad = nch * GROUP_W - 2 * n;
            code = code << pad;
            for (int k = 0; k < nch; k++) begin
                grp = int'((code >> (GROUP_W * (nch - 1 - k))) & 64'd31);
                beat.ch = GEO_ALPHABET[CHAR_W * (31 - grp) +: CHAR_W];
                beat.is_last = (k == nch - 1);
                beat.is_err = 1'b0;
                expected_chars = {expected_chars, beat};
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                encode_point(x_coord, y_coord);
                n_points++;
                if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
                    idle_left = $urandom_range(1, 12);
                end
            end
            if (!start || !busy) begin
                if (idle_left > 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (pending_points.size() != 0) begin
                    next_point = pending_points.pop_front();
                    start <= 1'b1;
                    x_coord <= next_point.x;
                    y_coord <= next_point.y;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_hash_beat want;
        if (i_rst_n && o_hash_valid) begin
            n_chars++;
            if (o_range_error) begin
                n_err_beats++;
            end
            if (expected_chars.size() == 0) begin
                report_mismatch("hash beat with no point pending", 32'(o_hash_char), 32'd0);
            end else begin
                want = expected_chars.pop_front();
                if (o_hash_char !== want.ch) begin
                    report_mismatch("hash_char", 32'(o_hash_char), 32'(want.ch));
                end
                if (o_last !== want.is_last) begin
                    report_mismatch("last", 32'(o_last), 32'(want.is_last));
                end
                if (o_range_error !== want.is_err) begin
                    report_mismatch("range_error", 32'(o_range_error), 32'(want.is_err));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_hash_valid || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: %0d cycles without a beat", stall_cycles);
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_point(input logic [31:0] xv, input logic [31:0] yv);
        t_point p;
        p.x = xv;
        p.y = yv;
        pending_points = {pending_points, p};
        n_queued++;
    endtask

    task automatic drain_hash();
        while (n_points != n_queued) begin
            @(posedge i_clk);
        end
        while (expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input t_reg_idx idx, input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_geometry(input logic [31:0] extent, input logic [31:0] axis_bits);
        logic [31:0] rd;
        apb_access(REG_MAX_COORD, 1'b1, extent, rd);
        extent_cfg = extent[MAXC_W-1:0];
        apb_access(REG_BITS_PER_AXIS, 1'b1, axis_bits, rd);
        axis_bits_cfg = axis_bits[BPA_W-1:0];
        apb_access(REG_MAX_COORD, 1'b0, '0, rd);
        if (rd[MAXC_W-1:0] !== extent_cfg) begin
            report_mismatch("max_coord readback", 32'(rd[MAXC_W-1:0]), 32'(extent_cfg));
        end
        apb_access(REG_BITS_PER_AXIS, 1'b0, '0, rd);
        if (rd[BPA_W-1:0] !== axis_bits_cfg) begin
            report_mismatch("bits_per_axis readback", 32'(rd[BPA_W-1:0]), 32'(axis_bits_cfg));
        end
        n_phases++;
    endtask

    function automatic logic [31:0] pick_coord(input logic [31:0] extent);
        logic [31:0] lim;
        lim = (extent == 0) ? 32'd1 : extent;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: pick_coord = $urandom % lim;
            5:             pick_coord = $urandom_range(0, (lim > 16) ? 15 : lim - 1);
            6:             pick_coord = lim - 1 - $urandom_range(0, (lim > 4) ? 3 : 0);
            7:             pick_coord = extent + $urandom_range(0, 2);
            8:             pick_coord = {1'b1, 31'($urandom)};
            default:       pick_coord = $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] extent, axis_bits, mc;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        mc = FULL_EXTENT;
        gap_pct = 30;
        queue_point(32'd0, 32'd0);
        queue_point(mc - 1, mc - 1);
        queue_point(32'd0, mc - 1);
        queue_point(mc - 1, 32'd0);
        queue_point(32'hffff_ffff, 32'd5);
        queue_point(32'd5, 32'hffff_ffff);
        queue_point(mc, 32'd0);
        queue_point(32'd0, mc);
        queue_point(32'h8000_0000, 32'h8000_0000);
        queue_point(32'h5555_5555, 32'h2aaa_aaaa);
        queue_point(32'h2aaa_aaaa, 32'h5555_5555);
        drain_hash();
        set_geometry(mc, 32'd0);
        queue_point(32'd123456789, 32'd987654321);
        queue_point(mc - 1, 32'd0);
        drain_hash();
        set_geometry(mc, 32'd1);
        queue_point(32'd1000, 32'd2000);
        drain_hash();
        set_geometry(mc, 32'd16);
        queue_point(mc - 1, mc - 1);
        queue_point(32'h1234_5678, 32'h0765_4321);
        drain_hash();
        set_geometry(mc, 32'd31);
        queue_point(32'h7fff_fffe, 32'd1);
        drain_hash();
        set_geometry(mc, 32'd3);
        queue_point(mc / 2, mc / 3);
        drain_hash();
        set_geometry(32'd1, 32'd5);
        queue_point(32'd0, 32'd0);
        queue_point(32'd1, 32'd0);
        queue_point(32'd0, 32'd1);
        drain_hash();
        set_geometry(32'd0, 32'd10);
        queue_point(32'd0, 32'd0);
        queue_point(32'd0, 32'hffff_ffff);
        drain_hash();

        for (int p = 0; p < 10; p++) begin
            case (p)
                0:       extent = FULL_EXTENT;
                1:       extent = 32'd1;
                2:       extent = 32'd0;
                3:       extent = $urandom_range(1, 100);
                4:       extent = $urandom_range(1, 65535);
                default: extent = $urandom_range(1, FULL_EXTENT);
            endcase
            case (p)
                0:       axis_bits = 32'd16;
                1:       axis_bits = 32'd0;
                3:       axis_bits = 32'd31;
                4:       axis_bits = 32'd1;
                5:       axis_bits = 32'd17;
                6:       axis_bits = 32'd2;
                default: axis_bits = $urandom_range(2, 16);
            endcase
            set_geometry(extent, axis_bits);
            gap_pct = (p == 4 || p >= 8) ? 0 : 35;
            for (int k = 0; k < ((p == 2) ? 20 : 46); k++) begin
                queue_point(pick_coord(extent), pick_coord(extent));
            end
            drain_hash();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            report_mismatch("characters never delivered", 32'd0, 32'(expected_chars.size()));
        end
        $display("Encoded %0d points into %0d hash beats (%0d range errors)",
                 n_points, n_chars, n_err_beats);
        $display("Covered %0d register settings, including zero and full extent and bit counts 0 to 31",
                 n_phases);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
